/* sv/bpkp_pkg.sv */
// Shared types and codes for the button press / keep pair detector.
package bpkp_pkg;

   localparam int CFG_BITS   = 16;
   localparam int PIN_BITS   = 4;
   localparam int EVENT_BITS = 2;
   localparam int FIELD_BUTTONS = 4;
   localparam int ELAPSED_BITS  = 16;

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PRESSED = 2'd1;
   localparam logic [1:0] PHASE_KEPT    = 2'd2;

   localparam logic [EVENT_BITS-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_SHORT  = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_PAIR   = 2'd2;
   localparam logic [EVENT_BITS-1:0] EV_CONFIG = 2'd3;

   localparam logic [1:0] CSR_ACTIVE_LEVEL = 2'd0;
   localparam logic [1:0] CSR_PRESS_TICKS  = 2'd1;
   localparam logic [1:0] CSR_KEEP_TICKS   = 2'd2;
   localparam logic [1:0] CSR_PAIR_TIMEOUT = 2'd3;

   typedef struct packed {
      logic [EVENT_BITS-1:0] event_code;
      logic                  pair_start;
      logic                  short_press;
   } lane_status_type;

   typedef struct packed {
      logic       delete_all;
      logic [1:0] delete_button;
      logic       pair_open;
      logic [1:0] pair_owner;
   } window_status_type;

endpackage

/* sv/bpkp_lane.sv */
// One button lane: saturating hold counter and idle / pressed / kept phase machine.
module bpkp_lane #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          level_active,
   input  logic [bpkp_pkg::CFG_BITS-1:0] press_ticks,
   input  logic [bpkp_pkg::CFG_BITS-1:0] keep_ticks,
   input  logic                          armed,
   output bpkp_pkg::lane_status_type     status
);

   localparam int CW = (COUNT_BITS > bpkp_pkg::CFG_BITS) ? COUNT_BITS : bpkp_pkg::CFG_BITS;

   logic [COUNT_BITS-1:0] hold_ff, hold_in;
   logic [1:0]            phase_ff, phase_in;
   logic [CW-1:0]         hold_wide;
   logic                  reach_press, reach_keep;

   always_comb begin
      if (!level_active) begin
         hold_in = '0;
      end else if (hold_ff != {COUNT_BITS{1'b1}}) begin
         hold_in = hold_ff + COUNT_BITS'(1);
      end else begin
         hold_in = hold_ff;
      end
      hold_wide   = CW'(hold_in);
      reach_press = hold_wide >= CW'(press_ticks);
      reach_keep  = hold_wide >= CW'(keep_ticks);

      phase_in = phase_ff;
      status   = '{event_code: bpkp_pkg::EV_NONE, pair_start: 1'b0, short_press: 1'b0};
      if (phase_ff == bpkp_pkg::PHASE_IDLE && reach_press) begin
         phase_in = bpkp_pkg::PHASE_PRESSED;
      end else if (phase_ff == bpkp_pkg::PHASE_PRESSED && reach_keep) begin
         phase_in = bpkp_pkg::PHASE_KEPT;
         if (armed) begin
            status.event_code = bpkp_pkg::EV_PAIR;
            status.pair_start = 1'b1;
         end
      end else if (hold_in == '0) begin
         // release: report by the phase left behind
         if (armed) begin
            case (phase_ff)
               bpkp_pkg::PHASE_KEPT: begin
                  status.event_code = bpkp_pkg::EV_CONFIG;
               end
               bpkp_pkg::PHASE_PRESSED: begin
                  status.event_code  = bpkp_pkg::EV_SHORT;
                  status.short_press = 1'b1;
               end
               default: begin
                  status.event_code = bpkp_pkg::EV_NONE;
               end
            endcase
         end
         phase_in = bpkp_pkg::PHASE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         phase_ff <= bpkp_pkg::PHASE_IDLE;
      end else if (step) begin
         hold_ff  <= hold_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* sv/bpkp_merge.sv */
// Merge stage: combines lane pair-start / short-press flags into the pairing window.
module bpkp_merge #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [NUM_BUTTONS-1:0]        pair_mask,
   input  logic [NUM_BUTTONS-1:0]        short_mask,
   input  logic [bpkp_pkg::CFG_BITS-1:0] timeout_ticks,
   output bpkp_pkg::window_status_type   status
);

   localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int EW = bpkp_pkg::ELAPSED_BITS;

   logic          open_ff, open_in;
   logic [IW-1:0] owner_ff, owner_in;
   logic [EW-1:0] elapsed_ff, elapsed_in;
   logic [EW-1:0] elapsed_inc;
   logic [IW-1:0] pair_idx;
   logic          any_pair, lower_pair, del, open_mid;
   logic [31:0]   owner_wide, del_wide;

   always_comb begin
      elapsed_inc = elapsed_ff;
      if (open_ff && elapsed_ff != {EW{1'b1}}) begin
         elapsed_inc = elapsed_ff + EW'(1);
      end
      any_pair   = |pair_mask;
      pair_idx   = '0;
      lower_pair = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (pair_mask[i]) begin
            pair_idx = IW'(i);
         end
         // a pair start ahead of the owner moves the window before its release
         if (pair_mask[i] && (IW'(i) < owner_ff)) begin
            lower_pair = 1'b1;
         end
      end
      del      = open_ff && short_mask[owner_ff] && !lower_pair;
      open_mid = any_pair ? 1'b1 : (del ? 1'b0 : open_ff);
      owner_in   = any_pair ? pair_idx : owner_ff;
      elapsed_in = any_pair ? '0 : elapsed_inc;
      open_in    = open_mid && !(elapsed_in > timeout_ticks);

      owner_wide = 32'(owner_in);
      del_wide   = del ? 32'(owner_ff) : 32'd0;
      status.delete_all    = del;
      status.delete_button = del_wide[1:0];
      status.pair_open     = open_in;
      status.pair_owner    = owner_wide[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         owner_ff   <= '0;
         elapsed_ff <= '0;
      end else if (step) begin
         open_ff    <= open_in;
         owner_ff   <= owner_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

/* sv/button_press_keep_pair_detector.sv */
// Top level: config registers, button lanes, window merge and result register.
//
//   channel | ports                       | role
//   req     | req_valid/ready, pin_levels | one sampled tick
//   rsp     | rsp_valid/ready, events...  | one result per tick
//   csr     | csr_write_enable/index/data | register writes
//
// One tick per cycle unless rsp stalls: all lanes and the window merge update in the
// accept cycle and the result lands in a single output register for the next cycle.
// A new tick is taken while the held result leaves in the same cycle.
// Synchronous reset clears counters, phases, window and output valid.
module button_press_keep_pair_detector #(
   parameter int NUM_BUTTONS = 4,
   parameter int COUNT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bpkp_pkg::PIN_BITS-1:0] req_pin_levels,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_event_b0,
   output logic [1:0]                    rsp_event_b1,
   output logic [1:0]                    rsp_event_b2,
   output logic [1:0]                    rsp_event_b3,
   output logic                          rsp_delete_all,
   output logic [1:0]                    rsp_delete_button,
   output logic                          rsp_pair_open,
   output logic [1:0]                    rsp_pair_owner,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [bpkp_pkg::CFG_BITS-1:0] csr_write_data
);

   logic                          active_level_ff;
   logic [bpkp_pkg::CFG_BITS-1:0] press_ticks_ff, keep_ticks_ff, timeout_ff;
   logic                          step, armed;
   logic [NUM_BUTTONS-1:0]        pair_mask, short_mask;
   logic [bpkp_pkg::FIELD_BUTTONS-1:0][1:0] ev;
   bpkp_pkg::lane_status_type     lane_status [NUM_BUTTONS];
   bpkp_pkg::window_status_type   win_status;

   logic                                    rsp_valid_ff;
   logic [bpkp_pkg::FIELD_BUTTONS-1:0][1:0] ev_ff;
   bpkp_pkg::window_status_type             win_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign armed     = keep_ticks_ff > press_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= 1'b0;
         press_ticks_ff  <= 16'd10;
         keep_ticks_ff   <= 16'd100;
         timeout_ff      <= 16'd1000;
      end else if (csr_write_enable) begin
         case (csr_index)
            bpkp_pkg::CSR_ACTIVE_LEVEL: active_level_ff <= csr_write_data[0];
            bpkp_pkg::CSR_PRESS_TICKS:  press_ticks_ff  <= csr_write_data;
            bpkp_pkg::CSR_KEEP_TICKS:   keep_ticks_ff   <= csr_write_data;
            bpkp_pkg::CSR_PAIR_TIMEOUT: timeout_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic level_active;
      if (i < bpkp_pkg::PIN_BITS) begin : g_pin
         assign level_active = req_pin_levels[i] == active_level_ff;
      end else begin : g_nopin
         assign level_active = 1'b0;
      end
      bpkp_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
         .clock        (clock),
         .reset        (reset),
         .step         (step),
         .level_active (level_active),
         .press_ticks  (press_ticks_ff),
         .keep_ticks   (keep_ticks_ff),
         .armed        (armed),
         .status       (lane_status[i])
      );
      assign pair_mask[i]  = lane_status[i].pair_start;
      assign short_mask[i] = lane_status[i].short_press;
   end

   for (genvar b = 0; b < bpkp_pkg::FIELD_BUTTONS; b++) begin : g_ev
      if (b < NUM_BUTTONS) begin : g_used
         assign ev[b] = lane_status[b].event_code;
      end else begin : g_unused
         assign ev[b] = bpkp_pkg::EV_NONE;
      end
   end

   bpkp_merge #(.NUM_BUTTONS(NUM_BUTTONS)) u_merge (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .pair_mask     (pair_mask),
      .short_mask    (short_mask),
      .timeout_ticks (timeout_ff),
      .status        (win_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the payload until the transaction completes
   always_ff @(posedge clock) begin
      if (step) begin
         ev_ff  <= ev;
         win_ff <= win_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_b0      = ev_ff[0];
   assign rsp_event_b1      = ev_ff[1];
   assign rsp_event_b2      = ev_ff[2];
   assign rsp_event_b3      = ev_ff[3];
   assign rsp_delete_all    = win_ff.delete_all;
   assign rsp_delete_button = win_ff.delete_button;
   assign rsp_pair_open     = win_ff.pair_open;
   assign rsp_pair_owner    = win_ff.pair_owner;

endmodule
